// ===== rtl/pwc_pkg.sv =====
// Shared types, constants and helpers for the periodic cell wrap block.
// No dependencies; every other file imports this package.
package pwc_pkg;

    localparam int CELL_WIDTH  = 21;
    localparam int POS_WIDTH   = 32;
    localparam int EPS_LSBS    = 2;
    localparam int SLOT_STRIDE = 21;
    localparam int CFG_WIDTH   = 63;
    localparam int CELL_FRAC   = 10;
    localparam int POS_FRAC    = 16;
    localparam int INV_WIDTH   = 32;
    localparam int INV_FRAC    = 24;
    localparam int MAT_N       = 9;
    localparam int DIV_SHIFT   = INV_FRAC + CELL_FRAC;
    localparam int MINOR_W     = 2 * CELL_WIDTH + 1;
    localparam int DET_W       = 3 * CELL_WIDTH + 1;
    localparam int DIV_W       = 64;
    localparam int SUM_W       = INV_FRAC + POS_FRAC;
    localparam int G_W         = INV_FRAC + 1;
    localparam int BACK_SHIFT  = INV_FRAC + CELL_FRAC - POS_FRAC;
    localparam int BACK_W      = G_W + CELL_WIDTH + 2;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_ROW0 = 2'd0;
    localparam cfg_index_t REG_ROW1 = 2'd1;
    localparam cfg_index_t REG_ROW2 = 2'd2;

    typedef logic [CFG_WIDTH-1:0] cfg_word_t;
    localparam cfg_word_t ROW0_RESET = cfg_word_t'(1) << CELL_FRAC;
    localparam cfg_word_t ROW1_RESET = cfg_word_t'(1) << (SLOT_STRIDE + CELL_FRAC);
    localparam cfg_word_t ROW2_RESET = cfg_word_t'(1) << (2 * SLOT_STRIDE + CELL_FRAC);

    typedef logic signed [CELL_WIDTH-1:0] cell_val_t;
    typedef cell_val_t cell_mat_t [0:MAT_N-1];
    typedef logic signed [INV_WIDTH-1:0] inv_val_t;
    typedef inv_val_t inv_mat_t [0:MAT_N-1];
    typedef logic signed [G_W-1:0] frac_t;
    typedef logic signed [POS_WIDTH-1:0] pos_t;

    localparam logic [INV_FRAC-1:0] EPS_VAL = INV_FRAC'(EPS_LSBS);

    typedef struct packed {
        logic busy;
        logic singular;
    } inv_status_t;

    function automatic cell_val_t slot_value(input cfg_word_t row, input int unsigned slot);
        return cell_val_t'(row[slot*SLOT_STRIDE +: CELL_WIDTH]);
    endfunction

endpackage

// ===== rtl/pwc_if.sv =====
// Valid/ready channel interfaces for position and wrapped-result beats.
// Depends on pwc_pkg.
interface pwc_in_if import pwc_pkg::*; ();
    logic valid;
    logic ready;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pwc_out_if import pwc_pkg::*; ();
    logic valid;
    logic ready;
    pos_t wrapped_x;
    pos_t wrapped_y;
    pos_t wrapped_z;
    logic singular;

    modport source (output valid, output wrapped_x, output wrapped_y, output wrapped_z,
                    output singular, input ready);
    modport sink (input valid, input wrapped_x, input wrapped_y, input wrapped_z,
                  input singular, output ready);
endinterface

// ===== rtl/pwc_inv.sv =====
// Cell registers and the inverse-cell sequencer: minors, determinant and a
// bit-serial divider for each Q8.24 inverse entry. Depends on pwc_pkg.
module pwc_inv import pwc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  cfg_word_t   cfg_data,
    output cell_mat_t   lattice,
    output inv_mat_t    inv,
    output inv_status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MINOR = 7'b0000010,
        ST_DET   = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_LOAD  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } inv_state_t;

    localparam logic [DIV_W-1:0] RND_LIMIT = DIV_W'(1) << INV_WIDTH;
    localparam logic [DIV_W-1:0] LIM_POS   = (DIV_W'(1) << (INV_WIDTH - 1)) - DIV_W'(1);
    localparam logic [DIV_W-1:0] LIM_NEG   = DIV_W'(1) << (INV_WIDTH - 1);

    inv_state_t                 state_reg;
    logic [3:0]                 step_reg;
    logic [5:0]                 bit_reg;
    logic                       singular_reg;
    cfg_word_t                  row_reg [0:2];
    inv_val_t                   inv_reg [0:MAT_N-1];
    logic signed [MINOR_W-1:0]  minor_reg [0:MAT_N-1];
    logic signed [DET_W-1:0]    det_reg;
    logic [DIV_W-1:0]           dmag_reg;
    logic                       neg_reg;
    logic [DIV_W-1:0]           rem_reg;
    logic [DIV_W-1:0]           lo_reg;
    logic [DIV_W-1:0]           quo_reg;

    cell_val_t                   op_a, op_b, op_c, op_d, det_cell;
    logic signed [2*CELL_WIDTH-1:0] prod_ad, prod_bc;
    logic signed [MINOR_W-1:0]   minor_val, det_minor, load_minor;
    logic signed [DET_W-1:0]     det_prod, det_next;
    logic [MINOR_W-1:0]          load_mag;
    logic                        load_neg;
    logic [DIV_W-1:0]            load_hi, load_lo;
    logic [DIV_W:0]              rem_shift;
    logic                        rem_ge;
    logic [DIV_W-1:0]            rem_next;
    logic [DIV_W-1:0]            quo_rnd, quo_lim, quo_sat;
    inv_val_t                    fin_val, sat_val;
    logic                        cfg_hit;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lattice[3*r+c] = slot_value(row_reg[r], c);
            end
        end
    end

    assign cfg_hit = cfg_we && (cfg_index == REG_ROW0 || cfg_index == REG_ROW1 ||
                                cfg_index == REG_ROW2);

    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin op_a = lattice[4]; op_b = lattice[5]; op_c = lattice[7]; op_d = lattice[8]; end
            4'd1:    begin op_a = lattice[2]; op_b = lattice[1]; op_c = lattice[8]; op_d = lattice[7]; end
            4'd2:    begin op_a = lattice[1]; op_b = lattice[2]; op_c = lattice[4]; op_d = lattice[5]; end
            4'd3:    begin op_a = lattice[5]; op_b = lattice[3]; op_c = lattice[8]; op_d = lattice[6]; end
            4'd4:    begin op_a = lattice[0]; op_b = lattice[2]; op_c = lattice[6]; op_d = lattice[8]; end
            4'd5:    begin op_a = lattice[2]; op_b = lattice[0]; op_c = lattice[5]; op_d = lattice[3]; end
            4'd6:    begin op_a = lattice[3]; op_b = lattice[4]; op_c = lattice[6]; op_d = lattice[7]; end
            4'd7:    begin op_a = lattice[1]; op_b = lattice[0]; op_c = lattice[7]; op_d = lattice[6]; end
            4'd8:    begin op_a = lattice[0]; op_b = lattice[1]; op_c = lattice[3]; op_d = lattice[4]; end
            default: begin op_a = '0; op_b = '0; op_c = '0; op_d = '0; end
        endcase
    end

    assign prod_ad   = op_a * op_d;
    assign prod_bc   = op_b * op_c;
    assign minor_val = MINOR_W'(prod_ad) - MINOR_W'(prod_bc);

    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin det_cell = lattice[0]; det_minor = minor_reg[0]; end
            4'd1:    begin det_cell = lattice[1]; det_minor = minor_reg[3]; end
            default: begin det_cell = lattice[2]; det_minor = minor_reg[6]; end
        endcase
    end

    assign det_prod = det_cell * det_minor;
    assign det_next = det_reg + det_prod;

    assign load_minor = minor_reg[step_reg];
    assign load_mag   = load_minor[MINOR_W-1] ? MINOR_W'(-load_minor) : MINOR_W'(load_minor);
    assign load_neg   = load_minor[MINOR_W-1] ^ det_reg[DET_W-1];
    assign load_hi    = DIV_W'(load_mag) >> (DIV_W - DIV_SHIFT);
    assign load_lo    = DIV_W'(load_mag) << DIV_SHIFT;
    assign sat_val    = load_neg ? inv_val_t'(LIM_NEG) : inv_val_t'(LIM_POS);

    assign rem_shift = {rem_reg, lo_reg[DIV_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dmag_reg};
    assign rem_next  = rem_ge ? DIV_W'(rem_shift - {1'b0, dmag_reg}) : DIV_W'(rem_shift);

    assign quo_rnd = (quo_reg <= RND_LIMIT && rem_reg >= dmag_reg - rem_reg) ?
                     quo_reg + DIV_W'(1) : quo_reg;
    assign quo_lim = neg_reg ? LIM_NEG : LIM_POS;
    assign quo_sat = (quo_rnd > quo_lim) ? quo_lim : quo_rnd;
    assign fin_val = neg_reg ? inv_val_t'(-quo_sat[INV_WIDTH-1:0])
                             : inv_val_t'(quo_sat[INV_WIDTH-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            bit_reg      <= '0;
            singular_reg <= 1'b0;
            row_reg[0]   <= ROW0_RESET;
            row_reg[1]   <= ROW1_RESET;
            row_reg[2]   <= ROW2_RESET;
            for (int i = 0; i < MAT_N; i++)
            begin
                inv_reg[i] <= (i % 4 == 0) ? inv_val_t'(1) <<< INV_FRAC : '0;
            end
        end
        else if (cfg_hit)
        begin
            row_reg[cfg_index] <= cfg_data;
            state_reg          <= ST_MINOR;
            step_reg           <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                end
                ST_MINOR:
                begin
                    if (step_reg == 4'(MAT_N - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DET;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_DET:
                begin
                    if (step_reg == 4'd2)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_CHECK:
                begin
                    singular_reg <= (det_reg == '0);
                    if (det_reg == '0)
                    begin
                        for (int i = 0; i < MAT_N; i++)
                        begin
                            inv_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    bit_reg <= '0;
                    if (load_hi >= dmag_reg)
                    begin
                        inv_reg[step_reg] <= sat_val;
                        if (step_reg == 4'(MAT_N - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'(DIV_W - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    inv_reg[step_reg] <= fin_val;
                    if (step_reg == 4'(MAT_N - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MINOR:
            begin
                minor_reg[step_reg] <= minor_val;
                det_reg             <= '0;
            end
            ST_DET:
            begin
                det_reg <= det_next;
            end
            ST_CHECK:
            begin
                dmag_reg <= det_reg[DET_W-1] ? DIV_W'(-det_reg) : DIV_W'(det_reg);
            end
            ST_LOAD:
            begin
                neg_reg <= load_neg;
                rem_reg <= load_hi;
                lo_reg  <= load_lo;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                lo_reg  <= {lo_reg[DIV_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
            end
            default:
            begin
            end
        endcase
    end

    assign inv             = inv_reg;
    assign status.busy     = (state_reg != ST_IDLE);
    assign status.singular = singular_reg;

endmodule

// ===== rtl/pwc_lane.sv =====
// One fractional-coordinate lane: position times one inverse-cell column,
// rounded to Q.24 and wrapped into [-eps, 1-eps). Depends on pwc_pkg.
module pwc_lane import pwc_pkg::*; (
    input  logic     clk,
    input  logic     en,
    input  pos_t     pos_x,
    input  pos_t     pos_y,
    input  pos_t     pos_z,
    input  inv_val_t inv0,
    input  inv_val_t inv1,
    input  inv_val_t inv2,
    output frac_t    frac
);

    logic signed [POS_WIDTH+INV_WIDTH-1:0] full0, full1, full2;
    logic [SUM_W-1:0]    prod_reg [0:2];
    logic [SUM_W-1:0]    sum_rnd;
    logic [INV_FRAC-1:0] frac_mod, frac_eps;
    frac_t               frac_reg;

    assign full0 = pos_x * inv0;
    assign full1 = pos_y * inv1;
    assign full2 = pos_z * inv2;

    assign sum_rnd  = prod_reg[0] + prod_reg[1] + prod_reg[2] + (SUM_W'(1) << (POS_FRAC - 1));
    assign frac_mod = sum_rnd[SUM_W-1:POS_FRAC];
    assign frac_eps = frac_mod + EPS_VAL;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= full0[SUM_W-1:0];
            prod_reg[1] <= full1[SUM_W-1:0];
            prod_reg[2] <= full2[SUM_W-1:0];
            frac_reg    <= frac_t'({1'b0, frac_eps}) - frac_t'({1'b0, EPS_VAL});
        end
    end

    assign frac = frac_reg;

endmodule

// ===== rtl/pwc_merge.sv =====
// Merge of the three lane fractions back through the cell: nine registered
// products, then per-axis sum, round, floor shift and saturate. Depends on pwc_pkg.
module pwc_merge import pwc_pkg::*; (
    input  logic      clk,
    input  logic      en,
    input  frac_t     frac0,
    input  frac_t     frac1,
    input  frac_t     frac2,
    input  cell_mat_t lattice,
    output pos_t      wrapped_x,
    output pos_t      wrapped_y,
    output pos_t      wrapped_z
);

    localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_MIN = -(64'sd1 <<< (POS_WIDTH - 1));

    logic signed [G_W+CELL_WIDTH-1:0] prod_reg [0:MAT_N-1];
    frac_t                            frac_in [0:2];
    pos_t                             col [0:2];

    function automatic pos_t round_sat(input logic signed [BACK_W-1:0] x);
        logic signed [BACK_W-1:0] y;
        logic signed [63:0]       ye;
        y  = (x + (BACK_W'(1) <<< (BACK_SHIFT - 1))) >>> BACK_SHIFT;
        ye = y;
        if (ye > POS_MAX)
            ye = POS_MAX;
        if (ye < POS_MIN)
            ye = POS_MIN;
        return pos_t'(ye[POS_WIDTH-1:0]);
    endfunction

    assign frac_in[0] = frac0;
    assign frac_in[1] = frac1;
    assign frac_in[2] = frac2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[3*k+j] <= frac_in[k] * lattice[3*k+j];
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            col[j] = round_sat(BACK_W'(prod_reg[j]) + BACK_W'(prod_reg[3+j]) +
                               BACK_W'(prod_reg[6+j]));
        end
    end

    assign wrapped_x = col[0];
    assign wrapped_y = col[1];
    assign wrapped_z = col[2];

endmodule

// ===== rtl/periodic_cell_wrap_top.sv =====
// Top level of the periodic cell wrap block: cell registers, inverse sequencer,
// three fraction lanes, merge stage and output register. Depends on pwc_pkg,
// pwc_if, pwc_inv, pwc_lane and pwc_merge.
//
// Usage:
//   pos_in carries one Q16.16 position per beat; wrap_out returns one wrapped
//   Q16.16 position plus the singular flag per beat, in order.
//   The cell is loaded over the write port (cfg_we, cfg_index, cfg_data),
//   one lattice row per write; the user must load it while no beat is in
//   flight, which the block does not enforce. After each row write the
//   sequencer forms nine minors, the determinant and a zero check (a singular
//   cell stops there), then each inverse entry through a one-bit-per-cycle
//   divider or straight to its saturated value; meanwhile pos_in.ready is low.
//   Datapath: one beat per cycle while wrap_out does not stall and the sequencer
//   is idle; a result passes the lane product, lane fraction, merge product and
//   output registers. The three lanes and the merge multipliers are fully pipelined.
//   Reset restores the identity cell and inverse; no clearing pass is needed.
//   A stall on wrap_out holds the whole pipeline and drops pos_in.ready;
//   no beat is lost.
module periodic_cell_wrap_top import pwc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_word_t  cfg_data,
    pwc_in_if.sink     pos_in,
    pwc_out_if.source  wrap_out
);

    cell_mat_t   lattice;
    inv_mat_t    inv;
    inv_status_t st;
    frac_t       frac0, frac1, frac2;
    pos_t        mx, my, mz;
    logic        en, take;
    logic        v1_reg, v2_reg, v3_reg, vout_reg;
    pos_t        wx_reg, wy_reg, wz_reg;
    logic        sing_reg;

    pwc_inv u_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lattice   (lattice),
        .inv       (inv),
        .status    (st)
    );

    pwc_lane u_lane0 (
        .clk (clk), .en (en),
        .pos_x (pos_in.pos_x), .pos_y (pos_in.pos_y), .pos_z (pos_in.pos_z),
        .inv0 (inv[0]), .inv1 (inv[3]), .inv2 (inv[6]),
        .frac (frac0)
    );

    pwc_lane u_lane1 (
        .clk (clk), .en (en),
        .pos_x (pos_in.pos_x), .pos_y (pos_in.pos_y), .pos_z (pos_in.pos_z),
        .inv0 (inv[1]), .inv1 (inv[4]), .inv2 (inv[7]),
        .frac (frac1)
    );

    pwc_lane u_lane2 (
        .clk (clk), .en (en),
        .pos_x (pos_in.pos_x), .pos_y (pos_in.pos_y), .pos_z (pos_in.pos_z),
        .inv0 (inv[2]), .inv1 (inv[5]), .inv2 (inv[8]),
        .frac (frac2)
    );

    pwc_merge u_merge (
        .clk       (clk),
        .en        (en),
        .frac0     (frac0),
        .frac1     (frac1),
        .frac2     (frac2),
        .lattice   (lattice),
        .wrapped_x (mx),
        .wrapped_y (my),
        .wrapped_z (mz)
    );

    assign en           = !vout_reg || wrap_out.ready;
    assign pos_in.ready = en && !st.busy;
    assign take         = pos_in.valid && pos_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= take;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vout_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v3_reg)
        begin
            wx_reg   <= st.singular ? '0 : mx;
            wy_reg   <= st.singular ? '0 : my;
            wz_reg   <= st.singular ? '0 : mz;
            sing_reg <= st.singular;
        end
    end

    assign wrap_out.valid     = vout_reg;
    assign wrap_out.wrapped_x = wx_reg;
    assign wrap_out.wrapped_y = wy_reg;
    assign wrap_out.wrapped_z = wz_reg;
    assign wrap_out.singular  = sing_reg;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        st.busy |-> !pos_in.ready)
        else $error("position beat offered while inverse is being computed");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (wrap_out.valid && !wrap_out.ready) |-> !pos_in.ready)
        else $error("input taken while output stalled");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (wrap_out.valid && wrap_out.singular) |->
        (wrap_out.wrapped_x == '0 && wrap_out.wrapped_y == '0 && wrap_out.wrapped_z == '0))
        else $error("singular result carries non-zero coordinates");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for periodic_cell_wrap_top: loads several cells, streams positions
// and compares every wrapped beat with an in-bench fixed-point wrap predictor.
// Depends on pwc_pkg, pwc_if and the block's RTL.
module tb_top import pwc_pkg::*; ();

    localparam cfg_index_t REG_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         STALL_LIMIT = 20000;
    localparam longint     FRAC_MASK = (64'd1 << INV_FRAC) - 1;

    typedef struct {
        pos_t x;
        pos_t y;
        pos_t z;
        logic sing;
    } wrapped_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_index_t cfg_index;
    cfg_word_t cfg_data;

    pwc_in_if  pos_ch ();
    pwc_out_if res_ch ();

    periodic_cell_wrap_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pos_in   (pos_ch.sink),
        .wrap_out (res_ch.source)
    );

    cfg_word_t cell_rows [0:2];
    longint    inv_ref [0:8];
    logic      cell_sing;
    wrapped_t  wrap_q [$];
    int        errors;
    bit        no_idle;
    bit        hold_req;
    int        hold_cnt;
    int        stall_cnt;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint cell_at(int r, int c);
        logic signed [CELL_WIDTH-1:0] v;
        v = cell_rows[r][c*SLOT_STRIDE +: CELL_WIDTH];
        return longint'(v);
    endfunction

    function automatic longint inv_entry(longint mn, longint det);
        bit           neg;
        logic [63:0]  n;
        logic [63:0]  d;
        logic [63:0]  q;
        logic [63:0]  limit;
        logic [127:0] num;
        logic [127:0] r;
        if (mn == 0)
            return 0;
        neg   = (mn < 0) != (det < 0);
        n     = (mn < 0) ? -mn : mn;
        d     = (det < 0) ? -det : det;
        limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if ((n >> 30) >= d)
            q = '1;
        else
        begin
            num = {64'd0, n} << 34;
            q   = 64'(num / d);
            r   = num % d;
            if (q <= 64'h1_0000_0000 && r >= (d - r))
                q = q + 1;
        end
        if (q > limit)
            q = limit;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void refresh_inverse();
        longint c [0:2][0:2];
        longint m [0:8];
        longint det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i][j] = cell_at(i, j);
        m[0] = c[1][1] * c[2][2] - c[1][2] * c[2][1];
        m[1] = c[0][2] * c[2][1] - c[0][1] * c[2][2];
        m[2] = c[0][1] * c[1][2] - c[0][2] * c[1][1];
        m[3] = c[1][2] * c[2][0] - c[1][0] * c[2][2];
        m[4] = c[0][0] * c[2][2] - c[0][2] * c[2][0];
        m[5] = c[0][2] * c[1][0] - c[0][0] * c[1][2];
        m[6] = c[1][0] * c[2][1] - c[1][1] * c[2][0];
        m[7] = c[0][1] * c[2][0] - c[0][0] * c[2][1];
        m[8] = c[0][0] * c[1][1] - c[0][1] * c[1][0];
        det = c[0][0] * m[0] + c[0][1] * m[3] + c[0][2] * m[6];
        cell_sing = (det == 0);
        for (int k = 0; k < 9; k++)
            inv_ref[k] = cell_sing ? 0 : inv_entry(m[k], det);
    endfunction

    function automatic wrapped_t wrap_position(pos_t px, pos_t py, pos_t pz);
        wrapped_t    w;
        longint      p [0:2];
        longint      g [0:2];
        longint      x;
        longint      y;
        logic [63:0] s;
        logic [63:0] t;
        pos_t        o [0:2];
        w.sing = cell_sing;
        if (cell_sing)
        begin
            w.x = '0;
            w.y = '0;
            w.z = '0;
            return w;
        end
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int j = 0; j < 3; j++)
        begin
            s = 0;
            for (int k = 0; k < 3; k++)
                s = s + 64'(p[k] * inv_ref[k*3+j]);
            t = ((s + 64'd32768) >> 16) & FRAC_MASK;
            t = (t + EPS_LSBS) & FRAC_MASK;
            g[j] = longint'(t) - EPS_LSBS;
        end
        for (int j = 0; j < 3; j++)
        begin
            x = 0;
            for (int k = 0; k < 3; k++)
                x = x + g[k] * cell_at(k, j);
            x = x + (64'd1 << 17);
            y = x >>> 18;
            if (y < -longint'(64'h8000_0000))
                y = -longint'(64'h8000_0000);
            if (y > longint'(64'h7fff_ffff))
                y = longint'(64'h7fff_ffff);
            o[j] = pos_t'(y);
        end
        w.x = o[0];
        w.y = o[1];
        w.z = o[2];
        return w;
    endfunction

    function automatic cfg_word_t pack_row(longint a, longint b, longint c);
        cfg_word_t r;
        r = '0;
        r[0 +: 21]  = a[20:0];
        r[21 +: 21] = b[20:0];
        r[42 +: 21] = c[20:0];
        return r;
    endfunction

    task automatic drain_wraps();
        while (wrap_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_row(cfg_index_t idx, cfg_word_t val);
        pos_ch.valid <= 1'b0;
        drain_wraps();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_ROW2)
        begin
            cell_rows[idx] = val;
            refresh_inverse();
        end
        repeat (3) @(posedge clk);
        while (!pos_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_cell(cfg_word_t r0, cfg_word_t r1, cfg_word_t r2);
        write_row(REG_ROW0, r0);
        write_row(REG_ROW1, r1);
        write_row(REG_ROW2, r2);
    endtask

    task automatic send_pos(pos_t px, pos_t py, pos_t pz);
        if (!no_idle && $urandom_range(99) < 32)
        begin
            pos_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= px;
        pos_ch.pos_y <= py;
        pos_ch.pos_z <= pz;
        do
            @(posedge clk);
        while (!pos_ch.ready);
        wrap_q.insert(wrap_q.size(), wrap_position(px, py, pz));
    endtask

    function automatic pos_t rand_pos(bit wide);
        if (wide)
            return pos_t'($urandom);
        return pos_t'($signed($urandom_range(32'd13107200)) - 32'sd6553600);
    endfunction

    function automatic longint rand_cell_val(int lo, int hi);
        return longint'($urandom_range(hi - lo)) + lo;
    endfunction

    task automatic test_identity_extremes();
        pos_t vals [0:5];
        vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000};
        for (int i = 0; i < 6; i++)
            send_pos(vals[i], vals[(i+2)%6], vals[(i+4)%6]);
    endtask

    task automatic test_triclinic();
        load_cell(pack_row(10240, 0, 0), pack_row(3072, 9216, 0), pack_row(-2048, 1024, 12288));
        send_pos(32'h0, 32'h0, 32'h0);
        send_pos(32'hfff6_0000, 32'h0014_0000, 32'h0001_8000);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pos(32'h000a_0000, 32'h0, 32'h0);
    endtask

    task automatic test_extreme_cells();
        load_cell(pack_row(32'hfffff, 0, 0), pack_row(0, 32'hfffff, 0), pack_row(0, 0, 32'hfffff));
        send_pos(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
        load_cell(pack_row(-1048576, 0, 0), pack_row(0, -1048576, 0), pack_row(0, 0, -1048576));
        send_pos(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        load_cell(pack_row(1, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 1));
        send_pos(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000);
        load_cell('1, '1, '1);
        send_pos(32'h0100_0000, 32'hff00_0000, 32'h0);
    endtask

    task automatic test_singular_and_unused();
        load_cell(pack_row(4096, 0, 0), pack_row(0, 0, 0), pack_row(0, 0, 4096));
        send_pos(32'h0005_0000, 32'h7fff_ffff, 32'h8000_0000);
        write_row(REG_UNUSED, pack_row(1024, 0, 0));
        send_pos(32'h0001_0000, 32'h0, 32'h0);
        write_row(REG_ROW1, pack_row(0, 4096, 0));
        send_pos(32'h0005_0000, 32'h0006_0000, 32'hfff9_0000);
        write_row(REG_ROW2, pack_row(0, 4096, 0));
        send_pos(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    endtask

    task automatic test_random_cells();
        longint a;
        for (int c = 0; c < 20; c++)
        begin
            if (c % 5 == 4)
                load_cell(cfg_word_t'({$urandom, $urandom}), cfg_word_t'({$urandom, $urandom}),
                          cfg_word_t'({$urandom, $urandom}));
            else
            begin
                a = rand_cell_val(2048, 40960);
                load_cell(pack_row(a, rand_cell_val(-5120, 5120), rand_cell_val(-5120, 5120)),
                          pack_row(rand_cell_val(-5120, 5120), rand_cell_val(2048, 40960),
                                   rand_cell_val(-5120, 5120)),
                          pack_row(rand_cell_val(-5120, 5120), rand_cell_val(-5120, 5120),
                                   rand_cell_val(2048, 40960)));
            end
            no_idle = (c == 7);
            for (int i = 0; i < 45; i++)
                send_pos(rand_pos(i % 6 == 0), rand_pos(i % 7 == 0), rand_pos(i % 5 == 0));
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_pos(rand_pos(1'b0), rand_pos(1'b0), rand_pos(1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end
        else if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end
        else
        begin
            if (hold_req)
                hold_req = 1'b0;
            hold_cnt     <= 0;
            res_ch.ready <= no_idle || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        wrapped_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (wrap_q.size() == 0)
            begin
                $display("%0t: unexpected beat x=%h y=%h z=%h s=%b", $time, res_ch.wrapped_x,
                         res_ch.wrapped_y, res_ch.wrapped_z, res_ch.singular);
                errors++;
            end
            else
            begin
                e = wrap_q.pop_front();
                if (res_ch.wrapped_x !== e.x || res_ch.wrapped_y !== e.y ||
                    res_ch.wrapped_z !== e.z || res_ch.singular !== e.sing)
                begin
                    $display("%0t: expected x=%h y=%h z=%h s=%b, got x=%h y=%h z=%h s=%b",
                             $time, e.x, e.y, e.z, e.sing, res_ch.wrapped_x,
                             res_ch.wrapped_y, res_ch.wrapped_z, res_ch.singular);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pos_ch.valid && pos_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_ROW0;
        cfg_data     = '0;
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0;
        pos_ch.pos_y = '0;
        pos_ch.pos_z = '0;
        errors       = 0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        stall_cnt    = 0;
        cell_rows    = '{ROW0_RESET, ROW1_RESET, ROW2_RESET};
        for (int k = 0; k < 9; k++)
            inv_ref[k] = (k % 4 == 0) ? (64'd1 << INV_FRAC) : 0;
        cell_sing = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_extremes();
        test_triclinic();
        test_extreme_cells();
        test_singular_and_unused();
        test_random_cells();
        test_backpressure();
        pos_ch.valid <= 1'b0;
        drain_wraps();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
